// ===== rtl/csrspmv_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector multiply core.
// Used by the datapath modules, the top level and the port checker.
package csrspmv_pkg;

    localparam int VALUE_W   = 32;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int NROWS_W   = 11;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int SUM_W     = VALUE_W + 17;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 48;
    localparam int OP_W      = 2;

    localparam logic [NROWS_W-1:0] NUM_ROWS_RESET = 11'd1024;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Beat kinds carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_NONZERO = 2'd1,
        OP_EMPTY   = 2'd2
    } op_t;

    // Contents of the stage that waits on the vector read
    typedef struct packed {
        logic                      valid;
        logic                      empty_row;
        logic                      row_end;
        logic                      in_range;
        logic signed [VALUE_W-1:0] value;
    } rd_stage_t;

endpackage

// ===== rtl/csrspmv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csrspmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read; read data holds while rd_en is low
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/csrspmv_mac.sv =====
// Multiply stage, saturating row accumulator, row counter and result register.
// Depends on csrspmv_pkg.
module csrspmv_mac (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  csrspmv_pkg::rd_stage_t                   rd_stage,
    input  logic signed [csrspmv_pkg::VALUE_W-1:0]   elem,
    input  logic [csrspmv_pkg::NROWS_W-1:0]          num_rows,
    output logic                                     rd_stage_take,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [csrspmv_pkg::ROW_W-1:0]            out_row_index,
    output logic signed [csrspmv_pkg::VALUE_W-1:0]   out_row_sum,
    output logic                                     out_last_row,
    output logic                                     out_overflow
);
    import csrspmv_pkg::*;

    // Product stage
    logic                     mul_valid_reg, mul_valid_next;
    logic                     mul_empty_reg;
    logic                     mul_end_reg;
    logic signed [PROD_W-1:0] mul_prod_reg;

    // Row state
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    logic                      sat_reg, sat_next;
    logic [ROW_W-1:0]          row_cnt_reg, row_cnt_next;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]          out_index_reg;
    logic signed [VALUE_W-1:0] out_sum_reg;
    logic                      out_last_reg;
    logic                      out_ovf_reg;

    logic                        mul_emits;
    logic                        out_free;
    logic                        mul_go;
    logic                        mul_free;
    logic signed [PROD_W-1:0]    prod;
    logic signed [SUM_W-1:0]     prod_q;
    logic signed [SUM_W-1:0]     sum_wide;
    logic                        sum_clip;
    logic signed [VALUE_W-1:0]   sum_sat;
    logic                        is_last;

    // Handshake between stages
    assign mul_emits     = mul_empty_reg || mul_end_reg;
    assign out_free      = !out_valid_reg || out_ready;
    assign mul_go        = mul_valid_reg && (!mul_emits || out_free);
    assign mul_free      = !mul_valid_reg || mul_go;
    assign rd_stage_take = mul_free;

    // Multiply value by the vector element
    assign prod = PROD_W'(rd_stage.value) * PROD_W'(elem);

    // Drop fraction bits (floor), add and clamp to the value range
    always_comb begin
        prod_q   = SUM_W'(mul_prod_reg >>> FRAC_BITS);
        sum_wide = SUM_W'(acc_reg) + prod_q;
        sum_clip = !((&sum_wide[SUM_W-1:VALUE_W-1]) || !(|sum_wide[SUM_W-1:VALUE_W-1]));
        if (sum_clip) begin
            sum_sat = sum_wide[SUM_W-1] ? VALUE_MIN : VALUE_MAX;
        end else begin
            sum_sat = sum_wide[VALUE_W-1:0];
        end
    end

    assign is_last = ({1'b0, row_cnt_reg} == (num_rows - NROWS_W'(1)));

    // Next state of the row and the stages
    always_comb begin
        mul_valid_next = mul_free ? rd_stage.valid : mul_valid_reg;
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        row_cnt_next   = row_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (mul_go) begin
            if (mul_emits) begin
                acc_next       = '0;
                sat_next       = 1'b0;
                row_cnt_next   = is_last ? '0 : row_cnt_reg + ROW_W'(1);
                out_valid_next = 1'b1;
            end else begin
                acc_next = sum_sat;
                sat_next = sat_reg || sum_clip;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (mul_free) begin
            mul_empty_reg <= rd_stage.empty_row;
            mul_end_reg   <= rd_stage.row_end;
            mul_prod_reg  <= prod;
        end
        if (mul_go && mul_emits) begin
            out_index_reg <= row_cnt_reg;
            out_last_reg  <= is_last;
            if (mul_empty_reg) begin
                out_sum_reg <= '0;
                out_ovf_reg <= 1'b0;
            end else begin
                out_sum_reg <= sum_sat;
                out_ovf_reg <= sat_reg || sum_clip;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row_index = out_index_reg;
    assign out_row_sum   = out_sum_reg;
    assign out_last_row  = out_last_reg;
    assign out_overflow  = out_ovf_reg;

endmodule

// ===== rtl/csr_sparse_matrix_vector_multiply_core.sv =====
// Top level of the CSR sparse matrix-vector multiply core: input beat decode,
// vector store, read stage and configuration. Depends on csrspmv_pkg,
// csrspmv_ram and csrspmv_mac.
//
//   channel  direction  tdata (low bit up)        tuser          tlast
//   s_       in         column[9:0] value[41:10]   operation[1:0] row_end
//   m_       out        row_index[9:0] sum[41:10]  overflow       last_row
//   cfg_     in         num_rows[10:0], written when cfg_wr_en is high
//
// One beat per cycle is sustained while the m_ side keeps up; the single
// multiply-accumulate and the registered vector store read allow that rate. A row
// result passes the read stage, the product stage and the result register after
// its closing beat. In-range loads write the store on acceptance and give no
// result. Reset clears control state only; the vector store needs no clearing
// pass. A stalled m_ side fills the two internal stages, then drops s_tready.
module csr_sparse_matrix_vector_multiply_core #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [csrspmv_pkg::NROWS_W-1:0]      cfg_wr_data,   // num_rows
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [csrspmv_pkg::S_DATA_W-1:0]     s_tdata,       // column, value
    input  logic [csrspmv_pkg::OP_W-1:0]         s_tuser,       // operation
    input  logic                                 s_tlast,       // row_end
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csrspmv_pkg::M_DATA_W-1:0]     m_tdata,       // row_index, row_sum
    output logic                                 m_tuser,       // overflow
    output logic                                 m_tlast        // last_row
);
    import csrspmv_pkg::*;

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);

    logic [NROWS_W-1:0]        num_rows_reg;
    rd_stage_t                 rd_stage_reg, rd_stage_next;
    logic                      rd_take;
    logic                      accept;
    op_t                       op;
    logic [COL_W-1:0]          column;
    logic signed [VALUE_W-1:0] value;
    logic [31:0]               col_ext;
    logic                      in_range;
    logic [ADDR_W-1:0]         addr;
    logic [VALUE_W-1:0]        rd_data;
    logic signed [VALUE_W-1:0] elem;
    logic [ROW_W-1:0]          res_index;
    logic signed [VALUE_W-1:0] res_sum;

    // Decode the input beat
    assign op       = op_t'(s_tuser);
    assign column   = s_tdata[COL_W-1:0];
    assign value    = s_tdata[COL_W+VALUE_W-1:COL_W];
    assign col_ext  = 32'(column);
    assign in_range = (col_ext < 32'(VECTOR_DEPTH));
    assign addr     = col_ext[ADDR_W-1:0];

    assign s_tready = !rd_stage_reg.valid || rd_take;
    assign accept   = s_tvalid && s_tready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= NUM_ROWS_RESET;
        end else if (cfg_wr_en) begin
            num_rows_reg <= cfg_wr_data;
        end
    end

    // Vector store: write on in-range load beats, read on every accepted beat
    csrspmv_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk     (aclk),
        .wr_en   (accept && (op == OP_LOAD) && in_range),
        .wr_addr (addr),
        .wr_data (value),
        .rd_en   (accept),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Read stage: hold while the product stage is busy
    always_comb begin
        rd_stage_next = rd_stage_reg;
        if (s_tready) begin
            rd_stage_next.valid     = accept && ((op == OP_NONZERO) || (op == OP_EMPTY));
            rd_stage_next.empty_row = (op == OP_EMPTY);
            rd_stage_next.row_end   = s_tlast;
            rd_stage_next.in_range  = in_range;
            rd_stage_next.value     = value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_stage_reg.valid <= 1'b0;
        end else begin
            rd_stage_reg.valid <= rd_stage_next.valid;
        end
        rd_stage_reg.empty_row <= rd_stage_next.empty_row;
        rd_stage_reg.row_end   <= rd_stage_next.row_end;
        rd_stage_reg.in_range  <= rd_stage_next.in_range;
        rd_stage_reg.value     <= rd_stage_next.value;
    end

    // Out-of-range columns contribute nothing
    assign elem = rd_stage_reg.in_range ? rd_data : '0;

    csrspmv_mac u_mac (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_stage      (rd_stage_reg),
        .elem          (elem),
        .num_rows      (num_rows_reg),
        .rd_stage_take (rd_take),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_row_index (res_index),
        .out_row_sum   (res_sum),
        .out_last_row  (m_tlast),
        .out_overflow  (m_tuser)
    );

    assign m_tdata = {(M_DATA_W-ROW_W-VALUE_W)'(0), res_sum, res_index};

endmodule

// ===== rtl/csrspmv_checker.sv =====
// Port-level checker for the CSR sparse matrix-vector multiply core, bound
// to the top level. Depends on csrspmv_pkg.
module csrspmv_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_wr_en,
    input logic [csrspmv_pkg::NROWS_W-1:0]    cfg_wr_data,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [csrspmv_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                               m_tuser,
    input logic                               m_tlast
);
    import csrspmv_pkg::*;

    logic [NROWS_W-1:0] nr_reg;
    logic [ROW_W-1:0]   exp_idx_reg;

    // Track the row count and the expected next row index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nr_reg      <= NUM_ROWS_RESET;
            exp_idx_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                nr_reg <= cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                exp_idx_reg <= m_tlast ? '0 : exp_idx_reg + ROW_W'(1);
            end
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[ROW_W-1:0] == exp_idx_reg)
        else $error("row index out of sequence");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == ({1'b0, m_tdata[ROW_W-1:0]} == (nr_reg - NROWS_W'(1))))
        else $error("last-row flag does not match row count");

endmodule

bind csr_sparse_matrix_vector_multiply_core csrspmv_checker u_csrspmv_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
);

// ===== tb/spmv_row_checker.sv =====
// Row-result checker for the CSR sparse matrix-vector multiply core.
// Watches the s_, m_ and cfg_ ports, predicts each row result and compares it
// with what leaves the core. Depends on csrspmv_pkg.
module spmv_row_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [csrspmv_pkg::NROWS_W-1:0]      cfg_wr_data,   // num_rows
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [csrspmv_pkg::S_DATA_W-1:0]     s_tdata,       // column, value
    input  logic [csrspmv_pkg::OP_W-1:0]         s_tuser,       // operation
    input  logic                                 s_tlast,       // row_end
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [csrspmv_pkg::M_DATA_W-1:0]     m_tdata,       // row_index, row_sum
    input  logic                                 m_tuser,       // overflow
    input  logic                                 m_tlast,       // last_row
    output int                                   mismatches,
    output int                                   pending
);
    import csrspmv_pkg::*;

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ROW_W-1:0]          row_index;
        logic signed [VALUE_W-1:0] row_sum;
        logic                      last_row;
        logic                      overflow;
    } row_result_t;

    // Shadow copy of the core's state
    logic signed [VALUE_W-1:0] vector_mem [1 << COL_W];
    logic signed [VALUE_W-1:0] row_acc;
    logic [ROW_W-1:0]          row_cnt;
    logic                      row_sat;
    logic [NROWS_W-1:0]        num_rows;
    row_result_t               rows_due [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Queue the finished row, then advance the row counter and clear the sum
    task automatic close_row(input logic signed [VALUE_W-1:0] sum, input logic ovf);
        row_result_t due;
        due.row_index = row_cnt;
        due.row_sum   = sum;
        due.last_row  = ({1'b0, row_cnt} == num_rows - 1'b1);
        due.overflow  = ovf;
        rows_due = {rows_due, due};
        row_cnt = due.last_row ? '0 : row_cnt + 1'b1;
        row_acc = '0;
        row_sat = 1'b0;
    endtask

    // Apply one input beat: store a vector element, multiply-accumulate, or
    // close an empty row
    task automatic accumulate_beat(input op_t op, input logic [COL_W-1:0] col,
                                   input logic signed [VALUE_W-1:0] val,
                                   input logic row_end);
        logic signed [PROD_W-1:0] product;
        logic signed [PROD_W-1:0] total;
        case (op)
            OP_LOAD: begin
                vector_mem[col] = val;
            end
            OP_NONZERO: begin
                product = val * vector_mem[col];
                // arithmetic shift drops the low bits, rounding toward minus infinity
                total = row_acc + (product >>> FRAC_BITS);
                if (total > VALUE_MAX) begin
                    total   = VALUE_MAX;
                    row_sat = 1'b1;
                end else if (total < VALUE_MIN) begin
                    total   = VALUE_MIN;
                    row_sat = 1'b1;
                end
                row_acc = total[VALUE_W-1:0];
                if (row_end)
                    close_row(row_acc, row_sat);
            end
            OP_EMPTY: begin
                close_row('0, 1'b0);
            end
            default: begin
            end
        endcase
    endtask

    // Compare one result beat with the oldest pending row
    task automatic check_row(input logic [M_DATA_W-1:0] data, input logic ovf,
                             input logic last);
        row_result_t due;
        if (rows_due.size() == 0) begin
            report_mismatch($sformatf("row %0d sum %h with no row pending",
                                      data[ROW_W-1:0], data[ROW_W +: VALUE_W]));
        end else begin
            due = rows_due.pop_front();
            if (data[ROW_W-1:0] !== due.row_index)
                report_mismatch($sformatf("row_index %0d, expected %0d",
                                          data[ROW_W-1:0], due.row_index));
            if (data[ROW_W +: VALUE_W] !== due.row_sum)
                report_mismatch($sformatf("row %0d row_sum %h, expected %h", due.row_index,
                                          data[ROW_W +: VALUE_W], due.row_sum));
            if (last !== due.last_row)
                report_mismatch($sformatf("row %0d last_row %b, expected %b",
                                          due.row_index, last, due.last_row));
            if (ovf !== due.overflow)
                report_mismatch($sformatf("row %0d overflow %b, expected %b",
                                          due.row_index, ovf, due.overflow));
        end
    endtask

    // Sample every port at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            row_acc  = '0;
            row_cnt  = '0;
            row_sat  = 1'b0;
            num_rows = NUM_ROWS_RESET;
            rows_due.delete();
        end else begin
            if (cfg_wr_en)
                num_rows = cfg_wr_data;
            if (m_tvalid && m_tready)
                check_row(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                accumulate_beat(op_t'(s_tuser), s_tdata[COL_W-1:0],
                                s_tdata[COL_W +: VALUE_W], s_tlast);
        end
        pending = rows_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the CSR sparse matrix-vector multiply core: clock, reset,
// beat stimulus, output back-pressure and the verdict. Depends on csrspmv_pkg,
// the core and spmv_row_checker.
module tb_top;
    import csrspmv_pkg::*;

    localparam logic [OP_W-1:0]    OP_UNUSED    = 2'd3;
    localparam logic [VALUE_W-1:0] ONE_Q        = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] LSB_NEG_Q    = 32'hFFFF_FFFF;
    localparam int                 HOLD_CYCLES  = 200;
    localparam int                 DRAIN_CYCLES = 8;
    localparam int                 PHASE_BEATS  = 135;
    localparam int                 NUM_PHASES   = 8;
    localparam int                 IDLE_PCT     = 17;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [NROWS_W-1:0]    cfg_wr_data;   // num_rows
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;       // column[9:0], value[41:10]
    logic [OP_W-1:0]       s_tuser;       // operation
    logic                  s_tlast;       // row_end
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;       // row_index[9:0], row_sum[41:10]
    logic                  m_tuser;       // overflow
    logic                  m_tlast;       // last_row

    int mismatches;
    int pending;
    int beats_sent = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;

    // Vector entries written so far; nonzeros only ever read these
    bit col_loaded [1 << COL_W];
    logic [COL_W-1:0] loaded_cols [$];

    csr_sparse_matrix_vector_multiply_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    spmv_row_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one beat and hold it until accepted; enter and leave at a falling edge
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [COL_W-1:0] col,
                             input logic [VALUE_W-1:0] val, input logic row_end);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W-VALUE_W-COL_W){1'b0}}, val, col};
        s_tlast  <= row_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic load_elem(input logic [COL_W-1:0] col, input logic [VALUE_W-1:0] val);
        send_beat(OP_LOAD, col, val, 1'($urandom_range(1)));
        if (!col_loaded[col]) begin
            col_loaded[col] = 1'b1;
            loaded_cols = {loaded_cols, col};
        end
    endtask

    function automatic logic [COL_W-1:0] pick_col();
        return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    endfunction

    // Mostly small Q16.16 values, some full range, some at the limits
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(32'h0004_0000) - 32'h0002_0000;
        if (r < 85)
            return $urandom;
        if (r < 93)
            return VALUE_MAX;
        return VALUE_MIN;
    endfunction

    task automatic send_empty_row();
        send_beat(OP_EMPTY, COL_W'($urandom_range(1023)), $urandom, 1'($urandom_range(1)));
    endtask

    // Nonzeros of one row; the last one closes it unless the row is left open
    task automatic send_nonzeros(input int count, input bit close);
        for (int k = 0; k < count; k++)
            send_beat(OP_NONZERO, pick_col(), pick_value(), close && (k == count - 1));
    endtask

    // Drop valid, wait out every pending row and the pipeline tail
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_num_rows(input logic [NROWS_W-1:0] rows);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rows;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int unsigned r;
        int phase_end;
        logic [NROWS_W-1:0] rows;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_LOAD;
        s_tlast     = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: two-row matrix so last_row comes up often
        write_num_rows(11'd2);
        load_elem(10'd0, VALUE_MAX);
        load_elem(10'd1023, VALUE_MIN);
        load_elem(10'd1, ONE_Q);
        load_elem(10'd2, LSB_NEG_Q);
        load_elem(10'h2AA, 32'hAAAA_5555);
        load_elem(10'h155, 32'h5555_AAAA);
        send_beat(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
        // small products, including a negative one that rounds down
        send_beat(OP_NONZERO, 10'd1, 32'h0003_0000, 1'b0);
        send_beat(OP_NONZERO, 10'd2, ONE_Q, 1'b0);
        send_beat(OP_NONZERO, 10'd2, 32'h0000_0001, 1'b1);
        // positive saturation on the final row
        send_beat(OP_NONZERO, 10'd0, VALUE_MAX, 1'b1);
        // saturate high, then low, then step back in: overflow stays set
        send_beat(OP_NONZERO, 10'd1023, VALUE_MIN, 1'b0);
        send_beat(OP_NONZERO, 10'd0, VALUE_MIN, 1'b0);
        send_beat(OP_NONZERO, 10'd1, ONE_Q, 1'b1);
        send_empty_row();
        // an open row is dropped by an empty row
        send_beat(OP_NONZERO, 10'd1, 32'h0005_0000, 1'b0);
        send_empty_row();
        send_beat(OP_NONZERO, 10'h2AA, 32'h7FFF_0001, 1'b1);
        send_beat(OP_NONZERO, 10'h155, VALUE_MIN, 1'b1);
        settle();

        // Random phases, one num_rows setting each
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       rows = 11'd1;
                1:       rows = 11'd1024;
                2:       rows = 11'd0;
                3:       rows = 11'd2047;
                4:       rows = 11'd5;
                5:       rows = NROWS_W'($urandom_range(1, 1024));
                6:       rows = 11'd3;
                default: rows = NROWS_W'($urandom_range(2047));
            endcase
            write_num_rows(rows);
            quiet = (phase == 1);
            if (phase == 2)
                hold_req = 1'b1;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    repeat ($urandom_range(1, 6))
                        load_elem(COL_W'($urandom_range(1023)), pick_value());
                end else if (r < 12) begin
                    send_beat(OP_UNUSED, COL_W'($urandom_range(1023)), $urandom,
                              1'($urandom_range(1)));
                end else if (r < 16) begin
                    send_nonzeros($urandom_range(1, 3), 1'b0);
                    send_empty_row();
                end else if (r < 22) begin
                    send_empty_row();
                end else begin
                    send_nonzeros($urandom_range(1, 6), 1'b1);
                end
            end
            settle();
        end
        quiet = 1'b0;

        if (mismatches == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/csrspmv_pkg.sv
rtl/csrspmv_ram.sv
rtl/csrspmv_mac.sv
rtl/csr_sparse_matrix_vector_multiply_core.sv
rtl/csrspmv_checker.sv
tb/spmv_row_checker.sv
tb/tb_top.sv
